// ===== rtl/bright_pixel_centroid_deviation_core_macros.svh =====
// Assertion macros shared by the centroid deviation core.
`ifndef BRIGHT_PIXEL_CENTROID_DEVIATION_CORE_MACROS_SVH
`define BRIGHT_PIXEL_CENTROID_DEVIATION_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define BPCD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bpcd: same-cycle check failed");
`define BPCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bpcd: next-cycle check failed");
`else
`define BPCD_ASSERT_NOW(label, clk, rst, ante, cons)
`define BPCD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/bpcd_pkg.sv =====
// Types and constants of the bright pixel centroid deviation core.
`timescale 1ns / 1ps
package bpcd_pkg;

   localparam int THR_W      = 18;
   localparam int WID_W      = 13;
   localparam int SQ_W       = 18;
   localparam int SUM_W      = 36;
   localparam int CNT_W      = 25;
   localparam int CTR_W      = 12;
   localparam int DEV_W      = 12;
   localparam int REM_W      = CNT_W + 1;
   localparam int DIFF_W     = SUM_W + 1;
   localparam int STEP_W     = $clog2(SUM_W);
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 18;

   localparam logic [THR_W-1:0] THR_RESET = 18'd60000;
   localparam logic [WID_W-1:0] WID_RESET = 13'd640;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH = 1'b1;

   localparam logic signed [DIFF_W-1:0] DEV_HI = 37'sd2047;
   localparam logic signed [DIFF_W-1:0] DEV_LO = -37'sd2048;

   // One queue entry: the pixel's mask bit plus a snapshot of the sums
   // as they stand after this pixel, used only on a frame end.
   typedef struct packed {
      logic             white;
      logic             frame_end;
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] count;
      logic [CTR_W-1:0] center;
   } qentry_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIVIDE,
      BK_FINISH
   } back_state_type;

endpackage

// ===== rtl/bpcd_req_if.sv =====
// Pixel request channel.
`timescale 1ns / 1ps
interface bpcd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] blue;
   logic [7:0] green;
   logic [7:0] red;
   logic       row_end;
   logic       frame_end;

   modport source (output valid, blue, green, red, row_end, frame_end, input ready);
   modport sink (input valid, blue, green, red, row_end, frame_end, output ready);
endinterface

// ===== rtl/bpcd_rsp_if.sv =====
// Result channel.
`timescale 1ns / 1ps
interface bpcd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           mask_white;
   logic                           frame_done;
   logic                           deviation_valid;
   logic signed [bpcd_pkg::DEV_W-1:0] deviation;

   modport source (output valid, mask_white, frame_done, deviation_valid, deviation,
                   input ready);
   modport sink (input valid, mask_white, frame_done, deviation_valid, deviation,
                 output ready);
endinterface

// ===== rtl/bpcd_front.sv =====
// Front end: brightness test, column tracking and the running sums.
`timescale 1ns / 1ps
module bpcd_front #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [bpcd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bpcd_pkg::CSR_DATA_W-1:0]    csr_write_data,
   bpcd_req_if.sink                           req_chan,
   output logic                               push_valid,
   input  logic                               push_ready,
   output bpcd_pkg::qentry_type               push_entry
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int SUMX_W = bpcd_pkg::SUM_W + 1;

   logic [bpcd_pkg::THR_W-1:0] thr_ff, thr_in;
   logic [bpcd_pkg::WID_W-1:0] width_ff, width_in;
   logic [COL_W-1:0]           col_ff, col_in;
   logic [bpcd_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [bpcd_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   logic [15:0]                sq_blue, sq_green, sq_red;
   logic [bpcd_pkg::SQ_W-1:0]  bright;
   logic                       white;
   logic [SUMX_W-1:0]          sum_ext;
   logic [bpcd_pkg::SUM_W-1:0] sum_acc;
   logic [bpcd_pkg::CNT_W-1:0] cnt_acc;
   logic                       accept;

   always_comb begin
      thr_in   = thr_ff;
      width_in = width_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            bpcd_pkg::CSR_THRESHOLD: begin
               thr_in = csr_write_data[bpcd_pkg::THR_W-1:0];
            end
            bpcd_pkg::CSR_IMAGE_WIDTH: begin
               width_in = csr_write_data[bpcd_pkg::WID_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      sq_blue  = 16'(req_chan.blue * req_chan.blue);
      sq_green = 16'(req_chan.green * req_chan.green);
      sq_red   = 16'(req_chan.red * req_chan.red);
      bright   = bpcd_pkg::SQ_W'(sq_blue) + bpcd_pkg::SQ_W'(sq_green)
               + bpcd_pkg::SQ_W'(sq_red);
      white    = bright >= thr_ff;

      // The column sum saturates rather than wrapping on very tall frames.
      sum_ext = {1'b0, sum_ff} + SUMX_W'(col_ff);
      sum_acc = sum_ff;
      cnt_acc = cnt_ff;
      if (white) begin
         sum_acc = sum_ext[SUMX_W-1] ? '1 : sum_ext[bpcd_pkg::SUM_W-1:0];
         if (cnt_ff != '1) begin
            cnt_acc = cnt_ff + 1'b1;
         end
      end

      push_valid            = req_chan.valid;
      req_chan.ready        = push_ready;
      accept                = req_chan.valid && push_ready;
      push_entry.white      = white;
      push_entry.frame_end  = req_chan.frame_end;
      push_entry.sum        = sum_acc;
      push_entry.count      = cnt_acc;
      push_entry.center     = width_ff[bpcd_pkg::WID_W-1:1];

      sum_in = sum_ff;
      cnt_in = cnt_ff;
      col_in = col_ff;
      if (accept) begin
         if (req_chan.frame_end) begin
            sum_in = '0;
            cnt_in = '0;
         end else begin
            sum_in = sum_acc;
            cnt_in = cnt_acc;
         end
         if (req_chan.row_end || req_chan.frame_end) begin
            col_in = '0;
         end else if (col_ff == COL_W'(MAX_WIDTH - 1)) begin
            col_in = '0;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= bpcd_pkg::THR_RESET;
         width_ff <= bpcd_pkg::WID_RESET;
         col_ff   <= '0;
         sum_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         thr_ff   <= thr_in;
         width_ff <= width_in;
         col_ff   <= col_in;
         sum_ff   <= sum_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== rtl/bpcd_queue.sv =====
// Short first-in first-out queue between the front and back ends.
`timescale 1ns / 1ps
module bpcd_queue #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  bpcd_pkg::qentry_type push_entry,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output bpcd_pkg::qentry_type pop_entry
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int LVL_W = $clog2(DEPTH + 1);

   bpcd_pkg::qentry_type slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic             do_push, do_pop;

   always_comb begin
      push_ready = level_ff != LVL_W'(DEPTH);
      pop_valid  = level_ff != '0;
      pop_entry  = slots_ff[rd_ptr_ff];
      do_push    = push_valid && push_ready;
      do_pop     = pop_valid && pop_ready;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end

      level_in = level_ff;
      if (do_push && !do_pop) begin
         level_in = level_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule

// ===== rtl/bpcd_back.sv =====
// Back end: frame-end division, centering, saturation and the result register.
`timescale 1ns / 1ps
module bpcd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  bpcd_pkg::qentry_type pop_entry,
   output logic                 div_busy,
   bpcd_rsp_if.source           rsp_chan
);

   bpcd_pkg::back_state_type state_ff, state_in;

   logic [bpcd_pkg::SUM_W-1:0]  quo_ff, quo_in;
   logic [bpcd_pkg::REM_W-1:0]  rem_ff, rem_in;
   logic [bpcd_pkg::CNT_W-1:0]  den_ff, den_in;
   logic [bpcd_pkg::CTR_W-1:0]  center_ff, center_in;
   logic [bpcd_pkg::STEP_W-1:0] step_ff, step_in;
   logic                        white_ff, white_in;

   logic                        out_valid_ff, out_valid_in;
   logic                        out_white_ff, out_white_in;
   logic                        out_done_ff, out_done_in;
   logic                        out_dvalid_ff, out_dvalid_in;
   logic [bpcd_pkg::DEV_W-1:0]  out_dev_ff, out_dev_in;

   logic                        out_free, out_load;
   logic [bpcd_pkg::REM_W-1:0]  rem_shift;
   logic                        fits;
   logic signed [bpcd_pkg::DIFF_W-1:0] diff;

   always_comb begin
      out_free  = !out_valid_ff || rsp_chan.ready;
      out_load  = 1'b0;
      pop_ready = 1'b0;
      state_in  = state_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      center_in = center_ff;
      step_in   = step_ff;
      white_in  = white_ff;

      out_white_in  = out_white_ff;
      out_done_in   = out_done_ff;
      out_dvalid_in = out_dvalid_ff;
      out_dev_in    = out_dev_ff;

      // One restoring division step: shift in the next dividend bit.
      rem_shift = {rem_ff[bpcd_pkg::REM_W-2:0], quo_ff[bpcd_pkg::SUM_W-1]};
      fits      = rem_shift >= bpcd_pkg::REM_W'(den_ff);
      diff      = $signed({1'b0, quo_ff}) - $signed(bpcd_pkg::DIFF_W'(center_ff));

      unique case (state_ff)
         bpcd_pkg::BK_IDLE: begin
            pop_ready = out_free;
            if (pop_valid && out_free) begin
               if (pop_entry.frame_end && pop_entry.count != '0) begin
                  quo_in    = pop_entry.sum;
                  rem_in    = '0;
                  den_in    = pop_entry.count;
                  center_in = pop_entry.center;
                  white_in  = pop_entry.white;
                  step_in   = '0;
                  state_in  = bpcd_pkg::BK_DIVIDE;
               end else begin
                  out_load      = 1'b1;
                  out_white_in  = pop_entry.white;
                  out_done_in   = pop_entry.frame_end;
                  out_dvalid_in = 1'b0;
                  out_dev_in    = '0;
               end
            end
         end
         bpcd_pkg::BK_DIVIDE: begin
            rem_in  = fits ? rem_shift - bpcd_pkg::REM_W'(den_ff) : rem_shift;
            quo_in  = {quo_ff[bpcd_pkg::SUM_W-2:0], fits};
            step_in = step_ff + 1'b1;
            if (step_ff == bpcd_pkg::STEP_W'(bpcd_pkg::SUM_W - 1)) begin
               state_in = bpcd_pkg::BK_FINISH;
            end
         end
         bpcd_pkg::BK_FINISH: begin
            if (out_free) begin
               out_load      = 1'b1;
               out_white_in  = white_ff;
               out_done_in   = 1'b1;
               out_dvalid_in = 1'b1;
               if (diff > bpcd_pkg::DEV_HI) begin
                  out_dev_in = bpcd_pkg::DEV_HI[bpcd_pkg::DEV_W-1:0];
               end else if (diff < bpcd_pkg::DEV_LO) begin
                  out_dev_in = bpcd_pkg::DEV_LO[bpcd_pkg::DEV_W-1:0];
               end else begin
                  out_dev_in = diff[bpcd_pkg::DEV_W-1:0];
               end
               state_in = bpcd_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = bpcd_pkg::BK_IDLE;
         end
      endcase

      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end

      div_busy                 = state_ff != bpcd_pkg::BK_IDLE;
      rsp_chan.valid           = out_valid_ff;
      rsp_chan.mask_white      = out_white_ff;
      rsp_chan.frame_done      = out_done_ff;
      rsp_chan.deviation_valid = out_dvalid_ff;
      rsp_chan.deviation       = $signed(out_dev_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bpcd_pkg::BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      den_ff        <= den_in;
      center_ff     <= center_in;
      step_ff       <= step_in;
      white_ff      <= white_in;
      out_white_ff  <= out_white_in;
      out_done_ff   <= out_done_in;
      out_dvalid_ff <= out_dvalid_in;
      out_dev_ff    <= out_dev_in;
   end

endmodule

// ===== rtl/bright_pixel_centroid_deviation_core.sv =====
// Top level of the bright pixel centroid deviation core.
`timescale 1ns / 1ps
`include "bright_pixel_centroid_deviation_core_macros.svh"
// Takes one BGR pixel per beat in raster order and returns one result beat
// per pixel: the mask bit and, on the last pixel of a frame with bright
// pixels, the average bright column minus half the image width, saturated to
// 12 bits. The front end accepts one pixel per clock while the queue has room
// and keeps the running sums; a queue of QUEUE_DEPTH entries feeds the back
// end. An ordinary pixel goes from the queue straight into the result
// register once that register is free. A frame-end pixel of a frame with
// bright pixels holds the back end through a load, 36 steps of the
// one-bit-per-clock restoring divider and a finish, while the front keeps
// accepting pixels until the queue fills. As the back end drains no faster
// than the front fills, the input then stalls at every such frame end, whatever
// the row length; between them the rate is one pixel per clock while results are taken.
module bright_pixel_centroid_deviation_core #(
   parameter int MAX_WIDTH   = 4096,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [bpcd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bpcd_pkg::CSR_DATA_W-1:0] csr_write_data,
   bpcd_req_if.sink                        req_chan,
   bpcd_rsp_if.source                      rsp_chan
);

   logic                 q_push_valid, q_push_ready;
   bpcd_pkg::qentry_type q_push_entry;
   logic                 q_pop_valid, q_pop_ready;
   bpcd_pkg::qentry_type q_pop_entry;
   logic                 div_busy;

   bpcd_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_chan       (req_chan),
      .push_valid     (q_push_valid),
      .push_ready     (q_push_ready),
      .push_entry     (q_push_entry)
   );

   bpcd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_entry (q_push_entry),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_entry  (q_pop_entry)
   );

   bpcd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (q_pop_valid),
      .pop_ready (q_pop_ready),
      .pop_entry (q_pop_entry),
      .div_busy  (div_busy),
      .rsp_chan  (rsp_chan)
   );

   // A valid deviation only ever rides on a frame's last pixel.
   `BPCD_ASSERT_NOW(a_dev_on_frame_end, clock, reset, rsp_chan.valid && rsp_chan.deviation_valid, rsp_chan.frame_done)
   // Without a valid deviation the field reads as zero.
   `BPCD_ASSERT_NOW(a_dev_zero, clock, reset, rsp_chan.valid && !rsp_chan.deviation_valid, rsp_chan.deviation == '0)
   // A frame end with bright pixels must start the divider.
   `BPCD_ASSERT_NEXT(a_div_start, clock, reset, q_pop_valid && q_pop_ready && q_pop_entry.frame_end && (q_pop_entry.count != '0), div_busy)
   // The back end takes nothing from the queue while dividing.
   `BPCD_ASSERT_NOW(a_no_pop_busy, clock, reset, div_busy, !q_pop_ready)

endmodule
